@@ hdl/lfpa_pkg.sv @@
// Shared constants and controller/datapath handshake types for the lidar frame parser.
// Used by every module of the block; has no dependencies of its own.
package lfpa_pkg;

	// Default frame geometry.
	localparam int POINTS_DEF      = 12;
	localparam int FRAME_BYTES_DEF = 47;

	// Fixed field and state widths.
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 6;
	localparam int SUM_W  = 20;
	localparam int MEAN_W = 16;
	localparam int VPT_W  = 4;

	// Offset of the first point's low distance byte.
	localparam int FIRST_POINT_OFS = 6;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERLEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLY   = 2'd2;

	localparam logic [BYTE_W-1:0] HEADER_RST = 8'd84;
	localparam logic [BYTE_W-1:0] VERLEN_RST = 8'd44;
	localparam logic [BYTE_W-1:0] POLY_RST   = 8'd77;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic step;    // consume the byte on rx_byte
		logic launch;  // frame passed its CRC, start the mean computation
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic at_last;    // the byte on rx_byte is the CRC byte of the frame
		logic crc_match;  // rx_byte equals the running CRC
		logic div_done;   // divider finishes on this edge
	} dp_stat_t;

endpackage

@@ hdl/lfpa_divider.sv @@
// Radix-2 restoring divider that turns the distance sum into a mean, one bit per cycle.
// Depends on lfpa_pkg for the sum and mean widths.
module lfpa_divider #(
	parameter int CNT_W = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lfpa_pkg::SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0]           divisor,
	output logic                       done,
	output logic [lfpa_pkg::MEAN_W-1:0] mean,
	output logic [CNT_W-1:0]           count
);

	localparam int SUM_W = lfpa_pkg::SUM_W;
	localparam int IT_W  = $clog2(SUM_W);

	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] den_q;
	logic [IT_W-1:0]  iter_q;
	logic             busy_q;

	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             fits;
	logic [CNT_W-1:0] rem_next;

	assign trial    = {rem_q, quo_q[SUM_W-1]};
	assign fits     = trial >= {1'b0, den_q};
	assign diff     = trial - {1'b0, den_q};
	assign rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

	assign done = busy_q && (iter_q == IT_W'(SUM_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			iter_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			iter_q <= '0;
		end else if (busy_q) begin
			iter_q <= iter_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

	// An empty frame reports a mean of zero rather than the divide-by-zero pattern.
	assign mean  = (den_q == '0) ? '0 : quo_q[lfpa_pkg::MEAN_W-1:0];
	assign count = den_q;

endmodule

@@ hdl/lfpa_datapath.sv @@
// Frame datapath: configuration registers, byte offset, CRC-8, distance sum and count.
// Depends on lfpa_pkg and instantiates lfpa_divider.
module lfpa_datapath #(
	parameter int POINTS      = lfpa_pkg::POINTS_DEF,
	parameter int FRAME_BYTES = lfpa_pkg::FRAME_BYTES_DEF,
	parameter int CNT_W       = $clog2(POINTS + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lfpa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [lfpa_pkg::BYTE_W-1:0]    cfg_data,
	input  logic [lfpa_pkg::BYTE_W-1:0]    rx_byte,
	input  lfpa_pkg::ctrl_cmd_t            cmd,
	output lfpa_pkg::dp_stat_t             stat,
	output logic [lfpa_pkg::MEAN_W-1:0]    mean_distance,
	output logic [lfpa_pkg::VPT_W-1:0]     valid_points
);

	localparam int BYTE_W = lfpa_pkg::BYTE_W;
	localparam int IDX_W  = lfpa_pkg::IDX_W;
	localparam int SUM_W  = lfpa_pkg::SUM_W;
	localparam int PT_W   = $clog2(FRAME_BYTES / 3 + 2);
	localparam int EXT_W  = (CNT_W > lfpa_pkg::VPT_W) ? CNT_W : lfpa_pkg::VPT_W;

	// Position inside a three-byte point record.
	localparam logic [1:0] PH_LOW  = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_SKIP = 2'd2;

	function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] x,
	                                                input logic [BYTE_W-1:0] poly);
		logic [BYTE_W-1:0] v;
		v = x;
		for (int b = 0; b < BYTE_W; b++) begin
			v = v[BYTE_W-1] ? ({v[BYTE_W-2:0], 1'b0} ^ poly) : {v[BYTE_W-2:0], 1'b0};
		end
		return v;
	endfunction

	logic [BYTE_W-1:0] header_q;
	logic [BYTE_W-1:0] verlen_q;
	logic [BYTE_W-1:0] poly_q;

	logic [IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0] crc_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [BYTE_W-1:0] low_q;
	logic [1:0]        phase_q;
	logic [PT_W-1:0]   pt_q;

	logic              in_points;
	logic              hdr_bad;
	logic              ver_bad;
	logic              restart;
	logic              low_hit;
	logic              high_hit;
	logic [15:0]       pt_dist;
	logic [CNT_W-1:0]  div_count;
	logic [EXT_W-1:0]  count_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= lfpa_pkg::HEADER_RST;
			verlen_q <= lfpa_pkg::VERLEN_RST;
			poly_q   <= lfpa_pkg::POLY_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				lfpa_pkg::CFG_HEADER: header_q <= cfg_data;
				lfpa_pkg::CFG_VERLEN: verlen_q <= cfg_data;
				lfpa_pkg::CFG_POLY:   poly_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign stat.at_last   = idx_q >= IDX_W'(FRAME_BYTES - 1);
	assign stat.crc_match = rx_byte == crc_q;

	assign in_points = idx_q >= IDX_W'(lfpa_pkg::FIRST_POINT_OFS);
	assign hdr_bad   = (idx_q == IDX_W'(0)) && (rx_byte != header_q);
	assign ver_bad   = (idx_q == IDX_W'(1)) && (rx_byte != verlen_q);
	assign restart   = hdr_bad || ver_bad || stat.at_last;

	// A low byte whose high byte would land on the CRC byte is not kept.
	assign low_hit  = in_points && (phase_q == PH_LOW) && (int'(pt_q) < POINTS) &&
	                  (int'(idx_q) + 1 < FRAME_BYTES - 1);
	assign high_hit = in_points && (phase_q == PH_HIGH) && (int'(pt_q) < POINTS);
	assign pt_dist  = {rx_byte, low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			crc_q   <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
			low_q   <= '0;
			phase_q <= PH_LOW;
			pt_q    <= '0;
		end else if (cmd.step) begin
			if (restart) begin
				idx_q   <= '0;
				crc_q   <= '0;
				sum_q   <= '0;
				cnt_q   <= '0;
				low_q   <= '0;
				phase_q <= PH_LOW;
				pt_q    <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
				crc_q <= crc8_step(crc_q ^ rx_byte, poly_q);
				if (low_hit) begin
					low_q <= rx_byte;
				end
				if (high_hit && (pt_dist != '0)) begin
					sum_q <= SUM_W'(sum_q + SUM_W'(pt_dist));
					cnt_q <= cnt_q + 1'b1;
				end
				if (in_points) begin
					if (phase_q == PH_SKIP) begin
						phase_q <= PH_LOW;
						pt_q    <= pt_q + 1'b1;
					end else begin
						phase_q <= phase_q + 1'b1;
					end
				end
			end
		end
	end

	lfpa_divider #(
		.CNT_W(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.launch),
		.dividend(sum_q),
		.divisor (cnt_q),
		.done    (stat.div_done),
		.mean    (mean_distance),
		.count   (div_count)
	);

	assign count_ext    = EXT_W'(div_count);
	assign valid_points = count_ext[lfpa_pkg::VPT_W-1:0];

endmodule

@@ hdl/lfpa_ctrl.sv @@
// Controller: byte and result handshakes, and sequencing of the mean computation.
// Depends on lfpa_pkg for the command and status types.
module lfpa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rx_valid,
	output logic                rx_stall,
	output logic                res_valid,
	input  logic                res_stall,
	input  lfpa_pkg::dp_stat_t  stat,
	output lfpa_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_OUT
	} state_t;

	state_t state_q;
	logic   res_valid_q;
	logic   accept;

	// Only a CRC byte has to wait, and only while the previous result is still in flight.
	assign rx_stall   = stat.at_last && (state_q != S_IDLE);
	assign accept     = rx_valid && !rx_stall;
	assign cmd.step   = accept;
	assign cmd.launch = accept && stat.at_last && stat.crc_match;
	assign res_valid  = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.launch) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (stat.div_done) begin
						state_q     <= S_OUT;
						res_valid_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (!res_stall) begin
						state_q     <= S_IDLE;
						res_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					res_valid_q <= 1'b0;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_stall_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> stat.at_last)
		else $error("byte stalled away from the CRC position");

	a_launch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.launch |-> (state_q == S_IDLE) && !res_valid_q)
		else $error("mean computation launched while a result is in flight");

	a_launch_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.launch |=> (state_q == S_DIV) && !res_valid_q)
		else $error("launch did not enter the divide state");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_valid_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q == (state_q == S_OUT))
		else $error("result valid out of step with the state");
`endif

endmodule

@@ hdl/lidar_frame_parse_average_top.sv @@
// Lidar frame parser and distance averager, top level.
// Bytes enter on the rx channel at up to one request per cycle. Each frame is FRAME_BYTES
// bytes: a header byte, a version/length byte, point records of three bytes from offset 6
// (distance low, distance high, intensity) and a final CRC-8 byte. A wrong header or
// version byte drops the byte and resynchronizes; a CRC mismatch drops the frame.
// A frame that passes its CRC gives one request on the res channel with the integer mean
// of its nonzero distances (0 if there are none) and their count.
// The result is computed by the bit-serial divider after the CRC byte is taken, one quotient
// bit per cycle over the 20-bit sum. Bytes are taken at one per cycle, also while the
// divider runs; only the CRC byte of the next frame waits on rx_stall until the previous
// result has been taken. A stalled result holds its value.
// Reset loads the register defaults (header 84, version 44, polynomial 77) and puts the
// parser at the start of a frame with nothing pending. Configuration writes take effect at
// once and are meant for times when no frame is in progress.
// Depends on lfpa_pkg, lfpa_ctrl, lfpa_datapath and lfpa_divider.
module lidar_frame_parse_average_top #(
	parameter int POINTS      = lfpa_pkg::POINTS_DEF,
	parameter int FRAME_BYTES = lfpa_pkg::FRAME_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lfpa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [lfpa_pkg::BYTE_W-1:0]    cfg_data,
	input  logic                           rx_valid,
	output logic                           rx_stall,
	input  logic [lfpa_pkg::BYTE_W-1:0]    rx_byte,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [lfpa_pkg::MEAN_W-1:0]    mean_distance,
	output logic [lfpa_pkg::VPT_W-1:0]     valid_points
);

	lfpa_pkg::ctrl_cmd_t cmd;
	lfpa_pkg::dp_stat_t  stat;

	lfpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	lfpa_datapath #(
		.POINTS     (POINTS),
		.FRAME_BYTES(FRAME_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.rx_byte      (rx_byte),
		.cmd          (cmd),
		.stat         (stat),
		.mean_distance(mean_distance),
		.valid_points (valid_points)
	);

endmodule
